[hdl/bpdr_pkg.sv]
// Package for the Bayer pixel to display RGB block: register indexes, CFA colour
// table, averaging reciprocals and the square-root constants of the gamma unit.
// Depends on nothing; imported by bpdr_gamma and the top level.
`default_nettype none

package bpdr_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	// Register indexes on the configuration port (byte address is 8 times the index).
	typedef enum logic [2:0] {
		REG_BLACK     = 3'd0,
		REG_WHITE     = 3'd1,
		REG_CFA       = 3'd2,
		REG_WB        = 3'd3,
		REG_CCM_RED   = 3'd4,
		REG_CCM_GREEN = 3'd5,
		REG_CCM_BLUE  = 3'd6,
		REG_GAMMA     = 3'd7
	} reg_idx_t;

	localparam logic [2:0]  CFA_RESET   = 3'd4;
	localparam logic [47:0] WB_RESET    = 48'h1000_1000_1000;
	localparam logic [47:0] CCM_R_RESET = 48'h0000_0000_1000;
	localparam logic [47:0] CCM_G_RESET = 48'h0000_1000_0000;
	localparam logic [47:0] CCM_B_RESET = 48'h1000_0000_0000;
	localparam logic [14:0] GAMMA_RESET = 15'd9011;
	localparam logic [14:0] GAMMA_MIN   = 15'd1024;

	localparam logic [16:0] Q16_ONE = 17'd65536;

	// Colour channel codes.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Colour of a site, indexed by pattern and then by {row parity, column parity}.
	localparam logic [1:0] CFA_TAB [4][4] = '{
		'{CH_RED,   CH_GREEN, CH_GREEN, CH_BLUE},
		'{CH_BLUE,  CH_GREEN, CH_GREEN, CH_RED},
		'{CH_GREEN, CH_RED,   CH_BLUE,  CH_GREEN},
		'{CH_GREEN, CH_BLUE,  CH_RED,   CH_GREEN}
	};

	// ceil(2^28 / count); exact floor division for numerators below 2^21.
	function automatic logic [28:0] avg_recip(input logic [3:0] cnt);
		logic [28:0] r;
		unique case (cnt)
			4'd1:    r = 29'd268435456;
			4'd2:    r = 29'd134217728;
			4'd3:    r = 29'd89478486;
			4'd4:    r = 29'd67108864;
			4'd5:    r = 29'd53687092;
			4'd6:    r = 29'd44739243;
			4'd7:    r = 29'd38347923;
			4'd8:    r = 29'd33554432;
			4'd9:    r = 29'd29826162;
			default: r = 29'd0;
		endcase
		return r;
	endfunction

	// Floor square root, evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r = '0;
		rem = x;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q30 factor 2^-(2^-(k+1)): repeated square roots starting from 2^-1/2.
	function automatic logic [63:0] gamma_root(input int k);
		logic [63:0] t;
		t = isqrt64(64'd1 << 59);
		for (int j = 0; j < 16; j++) begin
			if (j < k) begin
				t = isqrt64(t << 30);
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

[hdl/bpdr_div.sv]
// Pipelined restoring divider: one quotient bit per register stage, with a
// sideband that travels alongside. Uses nothing from the package.
`default_nettype none

module bpdr_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int Q_W   = 17,
	parameter int SB_W  = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [SB_W-1:0]  sb_in,
	output logic      [Q_W-1:0]   quo,
	output logic      [SB_W-1:0]  sb_out
);

	// The numerator bits above the quotient width must already be below den.
	logic [DEN_W-1:0] rem_s [1:Q_W];
	logic [Q_W-1:0]   lo_s  [1:Q_W];
	logic [SB_W-1:0]  sb_s  [1:Q_W];

	genvar i;
	for (i = 0; i < Q_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_p;
		logic [Q_W-1:0]   lo_p;
		logic [SB_W-1:0]  sb_p;
		logic [DEN_W:0]   t;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_p = DEN_W'(num[NUM_W-1:Q_W]);
			assign lo_p  = num[Q_W-1:0];
			assign sb_p  = sb_in;
		end else begin : g_next
			assign rem_p = rem_s[i];
			assign lo_p  = lo_s[i];
			assign sb_p  = sb_s[i];
		end

		assign t  = {rem_p, lo_p[Q_W-1]};
		assign ge = (t >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[i+1] <= '0;
			end else if (en) begin
				sb_s[i+1] <= sb_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
				lo_s[i+1]  <= {lo_p[Q_W-2:0], ge};
			end
		end
	end

	assign quo    = lo_s[Q_W];
	assign sb_out = sb_s[Q_W];

endmodule

`default_nettype wire

[hdl/bpdr_gamma.sv]
// Gamma encoder: log2 by repeated squaring, exponent division, 2^-x by a
// product of root factors, then scaling to a byte. Uses bpdr_pkg and bpdr_div.
`default_nettype none

module bpdr_gamma #(
	parameter int SB_W = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [14:0]     gamma,
	input  wire logic [16:0]     v_in,
	input  wire logic [SB_W-1:0] sb_in,
	output logic      [7:0]      byte_out,
	output logic      [SB_W-1:0] sb_out
);
	import bpdr_pkg::*;

	localparam int FL_W = SB_W + 2;   // sideband plus zero and saturate flags

	// Stage 0: leading one and normalization to [1,2) in Q16.
	logic [3:0]  p_lod;
	logic [16:0] m_norm;

	always_comb begin
		p_lod = '0;
		for (int i = 0; i < 16; i++) begin
			if (v_in[i]) begin
				p_lod = 4'(i);
			end
		end
		m_norm = 17'(v_in[15:0]) << (5'd16 - {1'b0, p_lod});
	end

	logic [16:0]     sq_m  [0:16];
	logic [15:0]     sq_fr [0:16];
	logic [3:0]      sq_p  [0:16];
	logic [FL_W-1:0] sq_fl [0:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_fl[0] <= '0;
		end else if (en) begin
			sq_fl[0] <= {sb_in, (v_in == 17'd0), v_in[16]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_m[0]  <= m_norm;
			sq_fr[0] <= '0;
			sq_p[0]  <= p_lod;
		end
	end

	// Sixteen squaring stages, one fraction bit each.
	genvar k;
	for (k = 0; k < 16; k++) begin : g_sq
		logic [33:0] sq;
		logic [17:0] m2;

		assign sq = 34'(sq_m[k]) * 34'(sq_m[k]);
		assign m2 = sq[33:16];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_fl[k+1] <= '0;
			end else if (en) begin
				sq_fl[k+1] <= sq_fl[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_m[k+1]  <= m2[17] ? m2[17:1] : m2[16:0];
				sq_fr[k+1] <= {sq_fr[k][14:0], m2[17]};
				sq_p[k+1]  <= sq_p[k];
			end
		end
	end

	// Exponent numerator: (16 - log2 v) * 4096 + gamma / 2.
	logic [20:0]     a_log;
	logic [32:0]     num_s17;
	logic [FL_W-1:0] fl_s17;

	assign a_log = 21'(21'd16 << 16) - 21'({sq_p[16], sq_fr[16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s17 <= '0;
		end else if (en) begin
			fl_s17 <= sq_fl[16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s17 <= {a_log, 12'd0} + 33'(gamma >> 1);
		end
	end

	logic [23:0]     e_q;
	logic [FL_W-1:0] e_fl;

	bpdr_div #(
		.NUM_W (33),
		.DEN_W (15),
		.Q_W   (24),
		.SB_W  (FL_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    (num_s17),
		.den    (gamma),
		.sb_in  (fl_s17),
		.quo    (e_q),
		.sb_out (e_fl)
	);

	// Sixteen stages of 2^-frac(e) as a Q30 product.
	logic [30:0]     ex_v  [1:16];
	logic [15:0]     ex_f  [1:16];
	logic [7:0]      ex_n  [1:16];
	logic [FL_W-1:0] ex_fl [1:16];

	for (k = 0; k < 16; k++) begin : g_exp
		localparam logic [63:0] TK = gamma_root(k);
		logic [30:0]     v_p;
		logic [15:0]     f_p;
		logic [7:0]      n_p;
		logic [FL_W-1:0] fl_p;
		logic [60:0]     pr;

		if (k == 0) begin : g_first
			assign v_p  = 31'(31'd1 << 30);
			assign f_p  = e_q[15:0];
			assign n_p  = e_q[23:16];
			assign fl_p = e_fl;
		end else begin : g_next
			assign v_p  = ex_v[k];
			assign f_p  = ex_f[k];
			assign n_p  = ex_n[k];
			assign fl_p = ex_fl[k];
		end

		assign pr = 61'(v_p) * 61'(TK[29:0]) + 61'(61'd1 << 29);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_fl[k+1] <= '0;
			end else if (en) begin
				ex_fl[k+1] <= fl_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ex_v[k+1] <= f_p[15-k] ? pr[60:30] : v_p;
				ex_f[k+1] <= f_p;
				ex_n[k+1] <= n_p;
			end
		end
	end

	// Integer part of the exponent as a rounded right shift to Q16.
	logic [63:0]     sh_sum;
	logic [16:0]     r_s18;
	logic [FL_W-1:0] fl_s18;

	assign sh_sum = 64'(ex_v[16]) + (64'd1 << (ex_n[16] + 8'd13));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s18 <= '0;
		end else if (en) begin
			fl_s18 <= ex_fl[16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s18 <= (ex_n[16] >= 8'd40) ? 17'd0 : 17'(sh_sum >> (ex_n[16] + 8'd14));
		end
	end

	// Byte scaling, with zero and full scale taking their fixed codes.
	logic [24:0] byte_p;
	logic [8:0]  byte_r;
	logic [7:0]  byte_s19;
	logic [FL_W-1:0] fl_s19;

	assign byte_p = 25'(r_s18) * 25'd255 + 25'd32768;
	assign byte_r = byte_p[24:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s19 <= '0;
		end else if (en) begin
			fl_s19 <= fl_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_s18[1]) begin
				byte_s19 <= 8'd0;
			end else if (fl_s18[0] || byte_r > 9'd255) begin
				byte_s19 <= 8'd255;
			end else begin
				byte_s19 <= byte_r[7:0];
			end
		end
	end

	assign byte_out = byte_s19;
	assign sb_out   = fl_s19[FL_W-1:2];

endmodule

`default_nettype wire

[hdl/bayer_pixel_to_display_rgb_top.sv]
// Bayer pixel to display RGB, top level: configuration registers, tap
// normalization, colour averaging, white balance, colour matrix and output.
// Depends on bpdr_pkg, bpdr_div and bpdr_gamma.
//
// Usage. Each input beat on the s_ channel carries the nine raw taps of one
// Bayer pixel's 3x3 window, already gathered at edge-clamped positions, with
// the centre's row and column parity and the frame edge flags in s_tuser.
// Each output beat on the m_ channel carries the three gamma-encoded bytes
// and the three linear samples at source depth; m_tuser is set when the
// linear fields are meaningful (demosaic on). With demosaic off the three
// bytes all carry the gray of the centre tap and the linear fields are zero.
//
// Timing. The datapath is one pipeline of 86 register stages. One beat can be
// accepted every cycle unless the output stalls; the rate is set by the
// single-bit divider stages and the one-multiply-per-stage squaring and
// exponent chains, all fully pipelined.
// When the receiver holds m_tready low with a beat waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
//
// Reset clears all valid bits and loads the documented register defaults. The user must
// write registers through the APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module bayer_pixel_to_display_rgb_top #(
	parameter int SAMPLE_BITS = bpdr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata from bit 0: tap_up_left, tap_up, tap_up_right, tap_left, tap_center,
	// tap_right, tap_down_left, tap_down, tap_down_right (16 bits each).
	input  wire logic [143:0] s_tdata,
	// tuser from bit 0: column_parity, row_parity, edge_flags[3:0].
	input  wire logic [5:0]   s_tuser,
	// Output stream.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata from bit 0: display_red, display_green, display_blue (8 bits each),
	// linear_red, linear_green, linear_blue (16 bits each).
	output logic      [71:0]  m_tdata,
	// tuser: linear_valid.
	output logic              m_tuser,
	// Configuration port.
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready
);
	import bpdr_pkg::*;

	localparam logic [15:0] SMAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [15:0] black_q;
	logic [15:0] white_q;
	logic [2:0]  cfa_q;
	logic [47:0] wb_q;
	logic [47:0] ccm_q [3];
	logic [14:0] gamma_q;
	logic        wr_en;
	reg_idx_t    wr_idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q  <= '0;
			white_q  <= '0;
			cfa_q    <= CFA_RESET;
			wb_q     <= WB_RESET;
			ccm_q[0] <= CCM_R_RESET;
			ccm_q[1] <= CCM_G_RESET;
			ccm_q[2] <= CCM_B_RESET;
			gamma_q  <= GAMMA_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_BLACK:     black_q  <= pwdata[15:0];
				REG_WHITE:     white_q  <= pwdata[15:0];
				REG_CFA:       cfa_q    <= pwdata[2:0];
				REG_WB:        wb_q     <= pwdata[47:0];
				REG_CCM_RED:   ccm_q[0] <= pwdata[47:0];
				REG_CCM_GREEN: ccm_q[1] <= pwdata[47:0];
				REG_CCM_BLUE:  ccm_q[2] <= pwdata[47:0];
				REG_GAMMA:     gamma_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_BLACK:     prdata = 64'(black_q);
			REG_WHITE:     prdata = 64'(white_q);
			REG_CFA:       prdata = 64'(cfa_q);
			REG_WB:        prdata = 64'(wb_q);
			REG_CCM_RED:   prdata = 64'(ccm_q[0]);
			REG_CCM_GREEN: prdata = 64'(ccm_q[1]);
			REG_CCM_BLUE:  prdata = 64'(ccm_q[2]);
			REG_GAMMA:     prdata = 64'(gamma_q);
			default:       prdata = '0;
		endcase
	end

	// The whole pipeline moves together; it only holds while a finished beat
	// sits unaccepted at the output.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic demosaic;
	assign demosaic = cfa_q[2];

	// Effective white level and normalization range. A white level at or below
	// black falls back to the sample maximum.
	logic [15:0] white_eff;
	logic [15:0] range_w;
	logic        all_zero;
	logic [14:0] gamma_eff;

	assign white_eff = (white_q > black_q) ? white_q : SMAX;
	assign all_zero  = (white_eff <= black_q);
	assign range_w   = white_eff - black_q;
	assign gamma_eff = (gamma_q < GAMMA_MIN) ? GAMMA_MIN : gamma_q;

	// ------------------------------------------------------------------
	// Stage 1: per-tap flags, divider numerator and tap colour.
	// ------------------------------------------------------------------
	logic [31:0] num_s1 [9];
	logic [1:0]  fl_s1  [9];   // {zero, one}
	logic [1:0]  ch_s1  [9];
	logic        v_s1;

	genvar t;
	for (t = 0; t < 9; t++) begin : g_tap
		localparam int DY = t / 3;
		localparam int DX = t % 3;
		logic [15:0] smp;
		logic [15:0] d;
		logic        rpar;
		logic        cpar;

		assign smp  = s_tdata[16*t +: 16];
		assign d    = smp - black_q;
		assign rpar = s_tuser[1] ^ ((DY == 0) && !s_tuser[4]) ^ ((DY == 2) && !s_tuser[5]);
		assign cpar = s_tuser[0] ^ ((DX == 0) && !s_tuser[2]) ^ ((DX == 2) && !s_tuser[3]);

		always_ff @(posedge clk) begin
			if (en) begin
				num_s1[t] <= {d, 16'd0} + 32'(range_w >> 1);
				fl_s1[t]  <= {all_zero || (smp <= black_q), smp >= white_eff};
				ch_s1[t]  <= CFA_TAB[cfa_q[1:0]][{rpar, cpar}];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	// ------------------------------------------------------------------
	// Normalization dividers, one lane per tap. Sideband is
	// {valid, colour, zero, one}; only lane 0's valid is used.
	// ------------------------------------------------------------------
	logic [16:0] q_d  [9];
	logic [4:0]  sb_d [9];

	for (t = 0; t < 9; t++) begin : g_div
		bpdr_div #(
			.NUM_W (32),
			.DEN_W (16),
			.Q_W   (17),
			.SB_W  (5)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.num    (num_s1[t]),
			.den    (range_w),
			.sb_in  ({v_s1, ch_s1[t], fl_s1[t]}),
			.quo    (q_d[t]),
			.sb_out (sb_d[t])
		);
	end

	// Stage 2: normalized taps in Q1.16.
	logic [16:0] n_s2  [9];
	logic [1:0]  ch_s2 [9];
	logic        v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				if (sb_d[i][1]) begin
					n_s2[i] <= '0;
				end else if (sb_d[i][0]) begin
					n_s2[i] <= Q16_ONE;
				end else begin
					n_s2[i] <= q_d[i];
				end
				ch_s2[i] <= sb_d[i][3:2];
			end
		end
	end

	// Stage 3: per-colour partial sums over the top and bottom halves.
	logic [19:0] sa_c [3];
	logic [19:0] sb_c [3];
	logic [19:0] sa_s3 [3];
	logic [19:0] sb_s3 [3];
	logic [1:0]  ch_s3 [9];
	logic [16:0] ncen_s3;
	logic        v_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sa_c[c] = '0;
			sb_c[c] = '0;
			for (int i = 0; i < 5; i++) begin
				if (ch_s2[i] == 2'(c)) begin
					sa_c[c] = sa_c[c] + 20'(n_s2[i]);
				end
			end
			for (int i = 5; i < 9; i++) begin
				if (ch_s2[i] == 2'(c)) begin
					sb_c[c] = sb_c[c] + 20'(n_s2[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s3   <= sa_c;
			sb_s3   <= sb_c;
			ch_s3   <= ch_s2;
			ncen_s3 <= n_s2[4];
		end
	end

	// Stage 4: total plus half the count, and the count's reciprocal.
	logic [3:0]  cnt_c  [3];
	logic [20:0] nr_s4  [3];
	logic [28:0] rc_s4  [3];
	logic [16:0] ncen_s4;
	logic        v_s4;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cnt_c[c] = '0;
			for (int i = 0; i < 9; i++) begin
				if (ch_s3[i] == 2'(c)) begin
					cnt_c[c] = cnt_c[c] + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				nr_s4[c] <= 21'(sa_s3[c]) + 21'(sb_s3[c]) + 21'(cnt_c[c] >> 1);
				rc_s4[c] <= avg_recip(cnt_c[c]);
			end
			ncen_s4 <= ncen_s3;
		end
	end

	// Stage 5: rounded average by reciprocal multiply.
	logic [49:0] avg_p  [3];
	logic [16:0] avg_s5 [3];
	logic [16:0] ncen_s5;
	logic        v_s5;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			avg_p[c] = 50'(nr_s4[c]) * 50'(rc_s4[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				avg_s5[c] <= avg_p[c][44:28];
			end
			ncen_s5 <= ncen_s4;
		end
	end

	// Stage 6: white-balance product.
	logic [32:0] wbp_s6 [3];
	logic [16:0] ncen_s6;
	logic        v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				wbp_s6[c] <= 33'(avg_s5[c]) * 33'(wb_q[16*c +: 16]);
			end
			ncen_s6 <= ncen_s5;
		end
	end

	// Stage 7: balanced value, rounded back to Q16.
	logic [21:0] bal_s7 [3];
	logic [16:0] ncen_s7;
	logic        v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				bal_s7[c] <= 22'((wbp_s6[c] + 33'd2048) >> 12);
			end
			ncen_s7 <= ncen_s6;
		end
	end

	// Stage 8: the nine colour-matrix products.
	logic signed [38:0] pr_s8 [3][3];
	logic [16:0] ncen_s8;
	logic        v_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s8[c][k] <= 39'(signed'(ccm_q[c][16*k +: 16]))
						* 39'(signed'({1'b0, bal_s7[k]}));
				end
			end
			ncen_s8 <= ncen_s7;
		end
	end

	// Stage 9: row sums clamped to 0..1; gray mode takes the centre tap.
	logic signed [40:0] acc_c [3];
	logic [40:0] acc_r [3];
	logic [16:0] lin_c [3];
	logic [16:0] lin_s9 [3];
	logic        v_s9;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_c[c] = 41'(pr_s8[c][0]) + 41'(pr_s8[c][1]) + 41'(pr_s8[c][2]);
			acc_r[c] = 41'(acc_c[c]) + 41'd2048;
			if (acc_c[c] <= 41'sd0) begin
				lin_c[c] = '0;
			end else if ((acc_r[c] >> 12) > 41'(Q16_ONE)) begin
				lin_c[c] = Q16_ONE;
			end else begin
				lin_c[c] = acc_r[c][28:12];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				lin_s9[c] <= demosaic ? lin_c[c] : ncen_s8;
			end
		end
	end

	// Valid bits for stages 2 to 9.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s2 <= sb_d[0][4];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Linear output at source depth; it rides the gamma pipeline as sideband.
	logic [33:0] sc_p [3];
	logic [15:0] sc_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sc_p[c] = (34'(lin_s9[c]) * 34'(SMAX) + 34'd32768) >> 16;
			if (!demosaic) begin
				sc_c[c] = '0;
			end else if (sc_p[c] > 34'(SMAX)) begin
				sc_c[c] = SMAX;
			end else begin
				sc_c[c] = sc_p[c][15:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Gamma encoders, one per channel; channel 0 carries valid and linear data.
	// ------------------------------------------------------------------
	logic [7:0]  disp [3];
	logic [49:0] gsb_out;

	bpdr_gamma #(
		.SB_W (50)
	) u_gamma_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gamma    (gamma_eff),
		.v_in     (lin_s9[0]),
		.sb_in    ({v_s9, demosaic, sc_c[2], sc_c[1], sc_c[0]}),
		.byte_out (disp[0]),
		.sb_out   (gsb_out)
	);

	bpdr_gamma #(
		.SB_W (1)
	) u_gamma_green (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gamma    (gamma_eff),
		.v_in     (lin_s9[1]),
		.sb_in    (1'b0),
		.byte_out (disp[1]),
		.sb_out   ()
	);

	bpdr_gamma #(
		.SB_W (1)
	) u_gamma_blue (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.gamma    (gamma_eff),
		.v_in     (lin_s9[2]),
		.sb_in    (1'b0),
		.byte_out (disp[2]),
		.sb_out   ()
	);

	assign m_tvalid = gsb_out[49];
	assign m_tuser  = gsb_out[48];
	assign m_tdata  = {gsb_out[47:0], disp[2], disp[1], disp[0]};

endmodule

`default_nettype wire
